/* hdl/ffha_pkg.sv */
// Shared types, constants and codes of the first-fit heap allocator.
package ffha_pkg;

    localparam int LEN_W      = 14;
    localparam int CNT_W      = 7;
    localparam int IDX_W      = 6;
    localparam int MAX_BLOCKS = 64;

    localparam logic [LEN_W-1:0] HEADER_BYTES = 14'd9;
    localparam logic [LEN_W-1:0] HEAP_BYTES   = 14'd8192;
    localparam logic [LEN_W-1:0] LIMIT_RESET  = 14'd8000;
    localparam logic [CNT_W-1:0] FULL_COUNT   = 7'd64;
    localparam logic [CNT_W-1:0] LAST_CYCLE   = 7'd64;

    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;
    localparam logic [1:0] CMD_COMBINE = 2'd2;
    localparam logic [1:0] CMD_NOP     = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_BADADDR = 2'd3;

    typedef struct packed {
        logic [1:0]       command;
        logic [LEN_W-1:0] request_size;
        logic [LEN_W-1:0] payload_address;
    } cmd_t;

    typedef struct packed {
        logic [LEN_W-1:0] result_address;
        logic [1:0]       status;
        logic [LEN_W-1:0] break_offset_now;
        logic [CNT_W-1:0] blocks_now;
    } res_t;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic             free;
    } blk_t;

    typedef struct packed {
        logic             shift;
        logic             push;
        logic [IDX_W-1:0] entry;
    } chain_ctl_t;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctl_t;

endpackage

/* hdl/ffha_cell.sv */
// One block-table cell: holds one block entry and on a shift takes its neighbor's entry, or push_data when loaded.
module ffha_cell (
    input  logic             clk,
    input  ffha_pkg::cell_ctl_t ctl,
    input  ffha_pkg::blk_t   right,
    input  ffha_pkg::blk_t   push_data,
    output ffha_pkg::blk_t   q
);
    import ffha_pkg::*;

    blk_t q_reg;
    blk_t q_next;

    always_comb
    begin
        q_next = q_reg;
        if (ctl.shift)
        begin
            q_next = ctl.load ? push_data : right;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;
endmodule

/* hdl/ffha_ctrl.sv */
// Command sequencer: streams the block table through the head cell and builds the result.
module ffha_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cmd_valid,
    output logic                     cmd_stall,
    input  ffha_pkg::cmd_t           cmd,
    output logic                     res_valid,
    input  logic                     res_stall,
    output ffha_pkg::res_t           res,
    input  logic                     cfg_we,
    input  logic [ffha_pkg::LEN_W-1:0] cfg_wdata,
    input  ffha_pkg::blk_t           head,
    output ffha_pkg::chain_ctl_t     chain,
    output ffha_pkg::blk_t           push_data
);
    import ffha_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cyc_reg, cyc_next;
    logic [1:0]       op_reg, op_next;
    logic [LEN_W-1:0] size_reg, size_next;
    logic [LEN_W-1:0] paddr_reg, paddr_next;
    logic [CNT_W-1:0] total_reg, total_next;
    logic [CNT_W-1:0] tnew_reg, tnew_next;
    logic [LEN_W-1:0] brk_reg, brk_next;
    logic [LEN_W-1:0] limit_reg, limit_next;
    logic [LEN_W-1:0] pos_reg, pos_next;
    logic             found_reg, found_next;
    logic             ins_reg, ins_next;
    logic [CNT_W-1:0] r_reg, r_next;
    logic [1:0]       status_reg, status_next;
    logic [LEN_W-1:0] addr_reg, addr_next;
    blk_t             hold_reg, hold_next;
    blk_t             ext_reg, ext_next;
    logic             res_valid_reg, res_valid_next;
    res_t             res_reg, res_next;

    logic [LEN_W-1:0] lim;
    logic             valid_e;
    logic             is_last;
    logic             fits;
    logic             big;
    logic             grow_ok;
    logic             app_ok;
    logic             merge;
    logic             split;
    blk_t             proc;
    logic [LEN_W-1:0] step_pos;
    logic [CNT_W-1:0] entry_w;

    always_comb
    begin
        lim      = (limit_reg > HEAP_BYTES) ? HEAP_BYTES : limit_reg;
        valid_e  = cyc_reg < total_reg;
        is_last  = (cyc_reg + 7'd1) == total_reg;
        fits     = head.free && (head.len >= size_reg);
        big      = {1'b0, head.len} > ({1'b0, size_reg} + {1'b0, HEADER_BYTES});
        grow_ok  = ({2'b0, brk_reg} + {2'b0, size_reg}) <= ({2'b0, lim} + {2'b0, head.len});
        app_ok   = ({2'b0, brk_reg} + {2'b0, size_reg} + {2'b0, HEADER_BYTES})
                   <= {2'b0, lim};
        step_pos = pos_reg + HEADER_BYTES + head.len;
        merge    = (op_reg == CMD_COMBINE) && valid_e && (cyc_reg != 7'd0)
                   && hold_reg.free && head.free;
        entry_w  = FULL_COUNT - r_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        cyc_next       = cyc_reg;
        op_next        = op_reg;
        size_next      = size_reg;
        paddr_next     = paddr_reg;
        total_next     = total_reg;
        tnew_next      = tnew_reg;
        brk_next       = brk_reg;
        limit_next     = cfg_we ? cfg_wdata : limit_reg;
        pos_next       = pos_reg;
        found_next     = found_reg;
        ins_next       = ins_reg;
        r_next         = r_reg;
        status_next    = status_reg;
        addr_next      = addr_reg;
        hold_next      = hold_reg;
        ext_next       = ext_reg;
        res_valid_next = res_valid_reg && res_stall;
        res_next       = res_reg;
        proc           = head;
        split          = 1'b0;
        chain.shift    = 1'b0;
        chain.push     = 1'b0;
        chain.entry    = entry_w[IDX_W-1:0];
        push_data      = hold_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next  = S_RUN;
                    cyc_next    = '0;
                    op_next     = cmd.command;
                    size_next   = cmd.request_size;
                    paddr_next  = cmd.payload_address;
                    tnew_next   = total_reg;
                    pos_next    = '0;
                    found_next  = 1'b0;
                    ins_next    = 1'b0;
                    r_next      = 7'd1;
                    status_next = ST_OK;
                    addr_next   = '0;
                end
            end
            S_RUN:
            begin
                chain.shift = 1'b1;
                unique case (op_reg)
                    CMD_ALLOC:
                    begin
                        if (valid_e && !found_reg)
                        begin
                            if (fits)
                            begin
                                found_next = 1'b1;
                                if (big && (total_reg == FULL_COUNT))
                                begin
                                    status_next = ST_FULL;
                                end
                                else
                                begin
                                    addr_next = pos_reg + HEADER_BYTES;
                                    proc.len  = size_reg;
                                    proc.free = 1'b0;
                                    if (big)
                                    begin
                                        split         = 1'b1;
                                        ext_next.len  = head.len - size_reg - HEADER_BYTES;
                                        ext_next.free = 1'b1;
                                        ins_next      = 1'b1;
                                        tnew_next     = tnew_reg + 7'd1;
                                    end
                                    else
                                    begin
                                        proc.len = head.len;
                                    end
                                end
                            end
                            else
                            begin
                                pos_next = step_pos;
                                if (is_last && head.free)
                                begin
                                    found_next = 1'b1;
                                    if (grow_ok)
                                    begin
                                        proc.len  = size_reg;
                                        proc.free = 1'b0;
                                        brk_next  = brk_reg + size_reg - head.len;
                                        addr_next = brk_reg - head.len;
                                    end
                                    else
                                    begin
                                        status_next = ST_NOSPACE;
                                    end
                                end
                            end
                        end
                        else if (!found_reg && (cyc_reg == total_reg))
                        begin
                            found_next = 1'b1;
                            if (total_reg == FULL_COUNT)
                            begin
                                status_next = ST_FULL;
                            end
                            else if (app_ok)
                            begin
                                proc.len  = size_reg;
                                proc.free = 1'b0;
                                tnew_next = tnew_reg + 7'd1;
                                addr_next = brk_reg + HEADER_BYTES;
                                brk_next  = brk_reg + size_reg + HEADER_BYTES;
                            end
                            else
                            begin
                                status_next = ST_NOSPACE;
                            end
                        end
                    end
                    CMD_RELEASE:
                    begin
                        if (valid_e && !found_reg)
                        begin
                            if ((pos_reg + HEADER_BYTES) == paddr_reg)
                            begin
                                found_next = 1'b1;
                                proc.free  = 1'b1;
                            end
                            else
                            begin
                                pos_next = step_pos;
                            end
                        end
                        else if (!found_reg && (cyc_reg == LAST_CYCLE))
                        begin
                            status_next = ST_BADADDR;
                        end
                    end
                    CMD_COMBINE:
                    begin
                        if (merge)
                        begin
                            tnew_next = tnew_reg - 7'd1;
                        end
                    end
                    default:
                    begin
                        proc = head;
                    end
                endcase

                if (merge)
                begin
                    hold_next.len = hold_reg.len + HEADER_BYTES + head.len;
                    r_next        = r_reg + 7'd1;
                end
                else
                begin
                    chain.push = cyc_reg != 7'd0;
                    if (ins_reg)
                    begin
                        hold_next = ext_reg;
                        ext_next  = proc;
                    end
                    else
                    begin
                        hold_next = proc;
                        if (!split)
                        begin
                            ext_next = ext_reg;
                        end
                    end
                end

                if (cyc_reg == LAST_CYCLE)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cyc_next = cyc_reg + 7'd1;
                end
            end
            S_DONE:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next           = 1'b1;
                    res_next.result_address  = (status_reg == ST_OK) ? addr_reg : '0;
                    res_next.status          = status_reg;
                    res_next.break_offset_now = brk_reg;
                    res_next.blocks_now      = tnew_reg;
                    total_next               = tnew_reg;
                    state_next               = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= '0;
            brk_reg       <= '0;
            limit_reg     <= LIMIT_RESET;
            res_valid_reg <= 1'b0;
            cyc_reg       <= '0;
            found_reg     <= 1'b0;
            ins_reg       <= 1'b0;
            r_reg         <= 7'd1;
            tnew_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            brk_reg       <= brk_next;
            limit_reg     <= limit_next;
            res_valid_reg <= res_valid_next;
            cyc_reg       <= cyc_next;
            found_reg     <= found_next;
            ins_reg       <= ins_next;
            r_reg         <= r_next;
            tnew_reg      <= tnew_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        size_reg   <= size_next;
        paddr_reg  <= paddr_next;
        pos_reg    <= pos_next;
        status_reg <= status_next;
        addr_reg   <= addr_next;
        hold_reg   <= hold_next;
        ext_reg    <= ext_next;
        res_reg    <= res_next;
    end

    assign cmd_stall = state_reg != S_IDLE;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
endmodule

/* hdl/first_fit_heap_allocator_unit.sv */
// Top level of the first-fit heap allocator: a chain of block cells and the command sequencer.
//
//   channel | signals                     | transaction when
//   cmd     | cmd_valid, cmd_stall, cmd   | cmd_valid high and cmd_stall low
//   res     | res_valid, res_stall, res   | res_valid high and res_stall low
//   cfg     | cfg_we, cfg_wdata           | cfg_we high
//
// Every command makes the block table take one full trip of shifts through the head cell,
// and the result is then registered in the S_DONE state.
// A result waiting under res_stall holds the sequencer until it is taken.
// Reset clears the block count, the break and the limit to 8000; the cells are not cleared.
module first_fit_heap_allocator_unit (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cmd_valid,
    output logic                     cmd_stall,
    input  ffha_pkg::cmd_t           cmd,
    output logic                     res_valid,
    input  logic                     res_stall,
    output ffha_pkg::res_t           res,
    input  logic                     cfg_we,
    input  logic [ffha_pkg::LEN_W-1:0] cfg_wdata
);
    import ffha_pkg::*;

    blk_t       cell_q [MAX_BLOCKS];
    chain_ctl_t chain;
    blk_t       push_data;

    ffha_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .head      (cell_q[0]),
        .chain     (chain),
        .push_data (push_data)
    );

    for (genvar k = 0; k < MAX_BLOCKS; k++)
    begin : g_cell
        cell_ctl_t ctl;
        blk_t      right;

        assign ctl = '{shift: chain.shift,
                       load:  chain.push && (chain.entry == IDX_W'(k))};
        if (k == MAX_BLOCKS - 1)
        begin : g_tail
            assign right = push_data;
        end
        else
        begin : g_body
            assign right = cell_q[k + 1];
        end

        ffha_cell u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .right     (right),
            .push_data (push_data),
            .q         (cell_q[k])
        );
    end
endmodule
